FILE: hdl/gqvg_pkg.sv
// ----------------------------------------------------------------------------
// gqvg_pkg
// Shared types, constants and helpers for the glyph quad vertex generator.
// ----------------------------------------------------------------------------
package gqvg_pkg;

    // Atlas layout: 16 columns, first glyph at code 32
    localparam logic [7:0] ATLAS_BASE = 8'd32;
    localparam logic [7:0] ATLAS_LAST = 8'd159;
    localparam logic [6:0] SPACE_LOW7 = 7'd32;
    localparam logic [3:0] ATLAS_ROW0 = 4'd2;

    // Width table index width (covers table depths of up to 256 entries)
    localparam int IDX_W = 8;

    // Stream payload widths
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 2;

    // Configuration register indexes (paddr[4:2])
    typedef enum logic [2:0] {
        REG_SCALE       = 3'd0,
        REG_CELL_WIDTH  = 3'd1,
        REG_CELL_HEIGHT = 3'd2,
        REG_U_STEP      = 3'd3,
        REG_V_STEP      = 3'd4
    } reg_idx_t;

    // Input op codes
    typedef enum logic {
        OP_GLYPH = 1'b0,
        OP_WIDTH = 1'b1
    } op_t;

    // Quad corners, emitted in this order
    typedef enum logic [1:0] {
        CORNER_BL = 2'd0,
        CORNER_BR = 2'd1,
        CORNER_TR = 2'd2,
        CORNER_TL = 2'd3
    } corner_t;

    // Width table write request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
    } wr_req_t;

    // Per-glyph quad parameters held while the four vertices go out
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [11:0]        qw;
        logic [11:0]        qh;
        logic [19:0]        u0;
        logic [19:0]        v0;
    } quad_t;

    // Clamp an 18-bit signed value to the 16-bit signed range
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
            r = 16'sh7FFF;
        else if (v < -18'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

FILE: hdl/gqvg_width_ram.sv
// ----------------------------------------------------------------------------
// gqvg_width_ram
// Glyph advance width table: one write and one registered read per cycle.
// Per-entry valid bits make unwritten entries read as zero right after reset.
// ----------------------------------------------------------------------------
module gqvg_width_ram #(
    parameter int ENTRIES = 128
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gqvg_pkg::wr_req_t         wr_req,
    input  logic                      rd_en,
    input  logic [gqvg_pkg::IDX_W-1:0] rd_idx,
    output logic [7:0]                rd_data
);
    import gqvg_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    logic [7:0]         mem [ENTRIES];
    logic [7:0]         mem_rd_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic               rd_ok_reg;

    // Storage array and read port
    always_ff @(posedge clk)
    begin
        if (wr_req.en)
        begin
            mem[wr_req.idx[AW-1:0]] <= wr_req.data;
        end
        if (rd_en)
        begin
            mem_rd_reg <= mem[rd_idx[AW-1:0]];
        end
    end

    // Valid bits, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_req.en)
            begin
                valid_reg[wr_req.idx[AW-1:0]] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= valid_reg[rd_idx[AW-1:0]];
            end
        end
    end

    assign rd_data = rd_ok_reg ? mem_rd_reg : 8'd0;

endmodule

FILE: hdl/glyph_quad_vertex_generator_top.sv
// ----------------------------------------------------------------------------
// glyph_quad_vertex_generator_top
// Right-aligned text quad generator: glyph codes in, four textured vertices
// out per visible glyph.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one transfer per character, last character of
//   the string first, or one width table write (op = 1). first_of_string
//   reloads the running x from anchor_x before the glyph's advance.
//   Output stream (m_axis_*): four vertex transfers per visible glyph,
//   corners bottom-left, bottom-right, top-right, top-left; tlast marks the
//   fourth. Spaces, control codes and rows below the screen emit nothing.
//   APB port: scale, cell size and texture steps; write only while idle.
//   Each glyph passes the glyph stage and the quad stage before its first
//   vertex is loaded into the output register. The four vertices of a
//   visible glyph share the single output register, so the next glyph enters
//   the quad stage as the last vertex leaves; width writes and glyphs that
//   emit nothing retire at one per cycle while the glyph stage is not held.
//   Reset clears the running x, restores the register defaults and marks the
//   whole width table as zero at once; no clearing pass is needed.
//   A stall on m_axis_tready holds the current vertex; the input side keeps
//   taking items until the glyph stage and the quad stage are both full.
// ----------------------------------------------------------------------------
module glyph_quad_vertex_generator_top #(
    parameter int WIDTH_ENTRIES = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: anchor_x[15:0], anchor_y[31:16], char_code[39:32],
    //        width_index[46:40], width_value[54:47], zero pad [55]
    input  logic [gqvg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: op[0], first_of_string[1]
    input  logic [gqvg_pkg::IN_USER_W-1:0]     s_axis_tuser,
    // Output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: pos_x[15:0], pos_y[31:16], tex_u[51:32], tex_v[71:52]
    output logic [gqvg_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // tuser: corner[1:0]
    output logic [gqvg_pkg::OUT_USER_W-1:0]    m_axis_tuser,
    output logic                               m_axis_tlast,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [4:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import gqvg_pkg::*;

    localparam logic [8:0] ENTRIES_W = 9'(WIDTH_ENTRIES);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3:0]  scale_reg;
    logic [7:0]  cell_width_reg;
    logic [7:0]  cell_height_reg;
    logic [15:0] u_step_reg;
    logic [15:0] v_step_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg       <= 4'd2;
            cell_width_reg  <= 8'd0;
            cell_height_reg <= 8'd0;
            u_step_reg      <= 16'd0;
            v_step_reg      <= 16'd0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_SCALE:       scale_reg       <= pwdata[3:0];
                REG_CELL_WIDTH:  cell_width_reg  <= pwdata[7:0];
                REG_CELL_HEIGHT: cell_height_reg <= pwdata[7:0];
                REG_U_STEP:      u_step_reg      <= pwdata[15:0];
                REG_V_STEP:      v_step_reg      <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        case (cfg_idx)
            REG_SCALE:       prdata = {28'd0, scale_reg};
            REG_CELL_WIDTH:  prdata = {24'd0, cell_width_reg};
            REG_CELL_HEIGHT: prdata = {24'd0, cell_height_reg};
            REG_U_STEP:      prdata = {16'd0, u_step_reg};
            REG_V_STEP:      prdata = {16'd0, v_step_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    op_t                in_op;
    logic               in_first;
    logic signed [15:0] in_ax;
    logic signed [15:0] in_ay;
    logic [7:0]         in_code;
    logic [6:0]         in_widx;
    logic [7:0]         in_wval;
    logic [7:0]         in_rd_idx;
    logic               in_range;
    logic               in_xfer;

    assign in_op     = op_t'(s_axis_tuser[0]);
    assign in_first  = s_axis_tuser[1];
    assign in_ax     = s_axis_tdata[15:0];
    assign in_ay     = s_axis_tdata[31:16];
    assign in_code   = s_axis_tdata[39:32];
    assign in_widx   = s_axis_tdata[46:40];
    assign in_wval   = s_axis_tdata[54:47];
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign in_rd_idx = in_code - ATLAS_BASE;
    assign in_range  = (in_code >= ATLAS_BASE) && (in_code <= ATLAS_LAST) &&
                       ({1'b0, in_rd_idx} < ENTRIES_W);

    // ------------------------------------------------------------------
    // Width table
    // ------------------------------------------------------------------
    wr_req_t    wr_req;
    logic       rd_en;
    logic [7:0] rd_data;

    always_comb
    begin
        wr_req.en   = in_xfer && (in_op == OP_WIDTH) && ({2'b0, in_widx} < ENTRIES_W);
        wr_req.idx  = {1'b0, in_widx};
        wr_req.data = in_wval;
    end

    assign rd_en = in_xfer && (in_op == OP_GLYPH) && in_range;

    gqvg_width_ram #(
        .ENTRIES (WIDTH_ENTRIES)
    ) u_width_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_req  (wr_req),
        .rd_en   (rd_en),
        .rd_idx  (in_rd_idx),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Glyph stage: advance running x, decide visibility, quad setup
    // ------------------------------------------------------------------
    logic               s1_valid_reg;
    op_t                s1_op_reg;
    logic               s1_first_reg;
    logic signed [15:0] s1_ax_reg;
    logic signed [15:0] s1_ay_reg;
    logic [7:0]         s1_code_reg;
    logic               s1_range_reg;
    logic signed [15:0] running_x_reg;

    logic signed [15:0] rx_base;
    logic [7:0]         adv;
    logic [11:0]        adv_scaled;
    logic signed [17:0] rx_diff;
    logic signed [15:0] rx_next;
    logic signed [17:0] ay_sum;
    logic               s1_emit;
    logic               s1_retire;
    logic [3:0]         glyph_row;
    logic [3:0]         glyph_col;
    quad_t              quad_next;

    assign rx_base    = s1_first_reg ? s1_ax_reg : running_x_reg;
    assign adv        = s1_range_reg ? rd_data : 8'd0;
    assign adv_scaled = {4'd0, adv} * {8'd0, scale_reg};
    assign rx_diff    = {{2{rx_base[15]}}, rx_base} - {6'd0, adv_scaled};
    assign rx_next    = sat16(rx_diff);
    assign ay_sum     = {{2{s1_ay_reg[15]}}, s1_ay_reg} + {10'd0, cell_height_reg};

    assign s1_emit = (s1_op_reg == OP_GLYPH) && (s1_code_reg >= ATLAS_BASE) &&
                     (s1_code_reg[6:0] != SPACE_LOW7) && (ay_sum > 18'sd0);

    assign glyph_row = s1_code_reg[7:4] - ATLAS_ROW0;
    assign glyph_col = s1_code_reg[3:0];

    always_comb
    begin
        quad_next.x  = rx_next;
        quad_next.y  = s1_ay_reg;
        quad_next.qw = {4'd0, cell_width_reg} * {8'd0, scale_reg};
        quad_next.qh = {4'd0, cell_height_reg} * {8'd0, scale_reg};
        quad_next.u0 = {16'd0, glyph_col} * {4'd0, u_step_reg};
        quad_next.v0 = {16'd0, glyph_row} * {4'd0, v_step_reg};
    end

    // ------------------------------------------------------------------
    // Quad stage and output register handshake
    // ------------------------------------------------------------------
    logic    q_valid_reg;
    corner_t corner_reg;
    corner_t corner_next;
    quad_t   quad_reg;
    logic    m_valid_reg;
    logic    q_adv;
    logic    q_free;

    assign q_adv     = q_valid_reg && (!m_valid_reg || m_axis_tready);
    assign q_free    = !q_valid_reg || (q_adv && (corner_reg == CORNER_TL));
    assign s1_retire = s1_valid_reg && (!s1_emit || q_free);

    assign s_axis_tready = !s1_valid_reg || s1_retire;

    always_comb
    begin
        case (corner_reg)
            CORNER_BL: corner_next = CORNER_BR;
            CORNER_BR: corner_next = CORNER_TR;
            CORNER_TR: corner_next = CORNER_TL;
            CORNER_TL: corner_next = CORNER_BL;
            default:   corner_next = CORNER_BL;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            q_valid_reg   <= 1'b0;
            corner_reg    <= CORNER_BL;
            m_valid_reg   <= 1'b0;
            running_x_reg <= 16'sd0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= in_xfer;
            end
            if (s1_retire && (s1_op_reg == OP_GLYPH))
            begin
                running_x_reg <= rx_next;
            end
            if (s1_retire && s1_emit)
            begin
                q_valid_reg <= 1'b1;
                corner_reg  <= CORNER_BL;
            end
            else if (q_adv)
            begin
                corner_reg <= corner_next;
                if (corner_reg == CORNER_TL)
                begin
                    q_valid_reg <= 1'b0;
                end
            end
            if (q_adv)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Vertex generation for the current corner
    // ------------------------------------------------------------------
    logic               add_w;
    logic               add_h;
    logic               add_v;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [19:0]        vu;
    logic [19:0]        vv;

    assign add_w = (corner_reg == CORNER_BR) || (corner_reg == CORNER_TR);
    assign add_h = (corner_reg == CORNER_TR) || (corner_reg == CORNER_TL);
    assign add_v = (corner_reg == CORNER_BL) || (corner_reg == CORNER_BR);

    assign vx = sat16({{2{quad_reg.x[15]}}, quad_reg.x} +
                      (add_w ? {6'd0, quad_reg.qw} : 18'sd0));
    assign vy = sat16({{2{quad_reg.y[15]}}, quad_reg.y} +
                      (add_h ? {6'd0, quad_reg.qh} : 18'sd0));
    assign vu = quad_reg.u0 + (add_w ? {4'd0, u_step_reg} : 20'd0);
    assign vv = quad_reg.v0 + (add_v ? {4'd0, v_step_reg} : 20'd0);

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [OUT_USER_W-1:0] m_user_reg;
    logic                  m_last_reg;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_op_reg    <= in_op;
            s1_first_reg <= in_first;
            s1_ax_reg    <= in_ax;
            s1_ay_reg    <= in_ay;
            s1_code_reg  <= in_code;
            s1_range_reg <= in_range;
        end
        if (s1_retire && s1_emit)
        begin
            quad_reg <= quad_next;
        end
        if (q_adv)
        begin
            m_data_reg <= {vv, vu, vy, vx};
            m_user_reg <= corner_reg;
            m_last_reg <= (corner_reg == CORNER_TL);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule
